@@ src/psirq_pkg.sv @@
// shared types and constants for the prescaled interrupt timer
`default_nettype none
package psirq_pkg;

  localparam int CNT_W = 10;

  localparam logic [CNT_W-1:0] CYCLE_BATCH_MAX = 10'd1023;
  localparam logic [CNT_W-1:0] SCANLINE_TICKS  = 10'd8;
  localparam logic [CNT_W-1:0] PPU_TICKS       = 10'd2;
  localparam logic [CNT_W-1:0] WRITE_TICKS     = 10'd1;

  localparam logic [3:0] REG_PAGE = 4'hC;

  localparam logic [1:0] DIR_UP   = 2'b01;
  localparam logic [1:0] DIR_DOWN = 2'b10;

  typedef enum logic [1:0] {
    MODE_CPU_WRITE = 2'd0,
    MODE_CYCLES    = 2'd1,
    MODE_PPU_ADDR  = 2'd2,
    MODE_SCANLINE  = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    SRC_CYCLES   = 2'd0,
    SRC_SCANLINE = 2'd1,
    SRC_PPU      = 2'd2,
    SRC_WRITE    = 2'd3
  } src_t;

  typedef enum logic [2:0] {
    REG_ENABLE_SET = 3'd0,
    REG_CONTROL    = 3'd1,
    REG_DISABLE    = 3'd2,
    REG_ENABLE     = 3'd3,
    REG_PRESCALE   = 3'd4,
    REG_COUNT      = 3'd5,
    REG_KEY        = 3'd6,
    REG_NONE       = 3'd7
  } reg_sel_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_TICK,
    ST_APPLY
  } state_t;

  // timer state seen by the tick unit
  typedef struct packed {
    logic       enabled;
    logic [7:0] control;
    logic [7:0] prescale;
    logic [7:0] count;
    logic       irq;
  } timer_t;

  // timer state as the tick unit returns it
  typedef struct packed {
    logic [7:0] prescale;
    logic [7:0] count;
    logic       irq;
  } tick_res_t;

endpackage
`default_nettype wire

@@ src/psirq_tick.sv @@
// one prescaler clock: prescaler step, counter step and interrupt check
`default_nettype none
module psirq_tick
  import psirq_pkg::*;
(
  input  timer_t    cur,
  output tick_res_t res
);

  logic [7:0] mask;
  logic [7:0] p;
  logic [7:0] p_nxt;
  logic [1:0] dir;
  logic       carry;
  logic [7:0] cnt_nxt;

  always_comb begin
    mask    = cur.control[2] ? 8'h07 : 8'hFF;
    dir     = cur.control[7:6];
    p       = cur.prescale & mask;
    p_nxt   = p;
    carry   = 1'b0;
    cnt_nxt = cur.count;
    res     = '{prescale: cur.prescale, count: cur.count, irq: cur.irq};
    if (cur.enabled) begin
      if (dir == DIR_UP) begin
        p_nxt = p + 8'd1;
        carry = (p_nxt & mask) == 8'h00;
      end else if (dir == DIR_DOWN) begin
        p_nxt = p - 8'd1;
        carry = (p_nxt & mask) == mask;
      end
      res.prescale = (cur.prescale & ~mask) | (p_nxt & mask);
      if (carry) begin
        // a frozen counter still gets the wrap check
        if (dir == DIR_UP) begin
          if (!cur.control[3]) begin
            cnt_nxt = cur.count + 8'd1;
          end
          if (cnt_nxt == 8'h00) begin
            res.irq = 1'b1;
          end
        end else begin
          if (!cur.control[3]) begin
            cnt_nxt = cur.count - 8'd1;
          end
          if (cnt_nxt == 8'hFF) begin
            res.irq = 1'b1;
          end
        end
        res.count = cnt_nxt;
      end
    end
  end

endmodule
`default_nettype wire

@@ src/prescaled_irq_counter.sv @@
// prescaled interrupt timer top level: request sequencer and timer registers
//
// usage:
//   in_* carries one event per request: a cpu write, a batch of cpu cycles,
//   a ppu address change or a scanline end. the low two control bits pick
//   which events clock the timer (cycles, eight per scanline, two per
//   changed ppu address, one per cpu write). writes to c000-cfff reach the
//   timer registers after any write clock.
//   out_* returns one result per request: interrupt line, counter and
//   prescaler as they stand after the request is applied.
//   the request's timer clocks (none, one, two, eight or up to 1023 for a
//   cycle batch) run one after another, each one pass through the single
//   tick unit; then the register write is done and the result registered.
//   in_tready is high only while the sequencer idles, so a new request is
//   taken only after the previous one has been applied.
//   a result waits in the output register while the receiver stalls; the
//   next request is still taken meanwhile, and its result is held back
//   until the register frees.
//   reset (synchronous, rst_n low) clears all timer registers, the ppu
//   address record and the output valid flag.
`default_nettype none
module prescaled_irq_counter
  import psirq_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // mode[1:0], address[17:2], write_data[25:18], cycle_count[35:26], zero pad
  input  wire logic [39:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // irq_pending[0], counter_value[8:1], prescaler_value[16:9], zero pad
  output logic [23:0]      out_tdata
);

  // sequencer
  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] tick_cnt_r, tick_cnt_nxt;
  logic [CNT_W-1:0] ticks_req;

  // latched request
  mode_t            mode_r, mode_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [7:0]       data_r, data_nxt;

  // timer registers
  logic             en_r, en_nxt;
  logic [7:0]       ctrl_r, ctrl_nxt;
  logic [7:0]       pre_r, pre_nxt;
  logic [7:0]       main_r, main_nxt;
  logic [7:0]       key_r, key_nxt;
  logic             irq_r, irq_nxt;
  logic [15:0]      prev_addr_r, prev_addr_nxt;

  // output register
  logic             out_valid_r, out_valid_nxt;
  logic [23:0]      out_data_r, out_data_nxt;

  // request fields
  mode_t            in_mode;
  logic [15:0]      in_addr;
  logic [7:0]       in_data;
  logic [CNT_W-1:0] in_cycles;
  src_t             src;
  reg_sel_t         reg_sel;

  timer_t           timer_cur;
  tick_res_t        timer_res;

  assign in_mode   = mode_t'(in_tdata[1:0]);
  assign in_addr   = in_tdata[17:2];
  assign in_data   = in_tdata[25:18];
  assign in_cycles = in_tdata[35:26];
  assign src       = src_t'(ctrl_r[1:0]);
  assign reg_sel   = reg_sel_t'(addr_r[2:0]);

  assign in_tready  = (state_r == ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // the shared unit: one prescaler clock per pass
  assign timer_cur = '{enabled: en_r, control: ctrl_r, prescale: pre_r,
                       count: main_r, irq: irq_r};

  psirq_tick u_tick (
    .cur (timer_cur),
    .res (timer_res)
  );

  // number of clocks the incoming request produces
  always_comb begin
    ticks_req = '0;
    unique case (in_mode)
      MODE_CPU_WRITE: begin
        if (src == SRC_WRITE) begin
          ticks_req = WRITE_TICKS;
        end
      end
      MODE_CYCLES: begin
        if (src == SRC_CYCLES) begin
          ticks_req = (in_cycles > CYCLE_BATCH_MAX) ? CYCLE_BATCH_MAX : in_cycles;
        end
      end
      MODE_PPU_ADDR: begin
        if (src == SRC_PPU && prev_addr_r != in_addr) begin
          ticks_req = PPU_TICKS;
        end
      end
      MODE_SCANLINE: begin
        if (src == SRC_SCANLINE) begin
          ticks_req = SCANLINE_TICKS;
        end
      end
      default: begin
        ticks_req = '0;
      end
    endcase
  end

  // next state and register updates
  always_comb begin
    state_nxt     = state_r;
    tick_cnt_nxt  = tick_cnt_r;
    mode_nxt      = mode_r;
    addr_nxt      = addr_r;
    data_nxt      = data_r;
    en_nxt        = en_r;
    ctrl_nxt      = ctrl_r;
    pre_nxt       = pre_r;
    main_nxt      = main_r;
    key_nxt       = key_r;
    irq_nxt       = irq_r;
    prev_addr_nxt = prev_addr_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_tvalid) begin
          mode_nxt     = in_mode;
          addr_nxt     = in_addr;
          data_nxt     = in_data;
          tick_cnt_nxt = ticks_req;
          // ppu address record follows every ppu request
          if (in_mode == MODE_PPU_ADDR) begin
            prev_addr_nxt = in_addr;
          end
          state_nxt = (ticks_req != '0) ? ST_TICK : ST_APPLY;
        end
      end
      ST_TICK: begin
        pre_nxt      = timer_res.prescale;
        main_nxt     = timer_res.count;
        irq_nxt      = timer_res.irq;
        tick_cnt_nxt = tick_cnt_r - {{(CNT_W-1){1'b0}}, 1'b1};
        if (tick_cnt_r == {{(CNT_W-1){1'b0}}, 1'b1}) begin
          state_nxt = ST_APPLY;
        end
      end
      ST_APPLY: begin
        // wait for a free output slot, then do the register write
        if (!out_valid_r || out_tready) begin
          if (mode_r == MODE_CPU_WRITE && addr_r[15:12] == REG_PAGE) begin
            unique case (reg_sel)
              REG_ENABLE_SET: begin
                en_nxt = data_r[0];
                if (!data_r[0]) begin
                  pre_nxt = 8'h00;
                  irq_nxt = 1'b0;
                end
              end
              REG_CONTROL: begin
                ctrl_nxt = data_r;
              end
              REG_DISABLE: begin
                en_nxt  = 1'b0;
                pre_nxt = 8'h00;
                irq_nxt = 1'b0;
              end
              REG_ENABLE: begin
                en_nxt = 1'b1;
              end
              REG_PRESCALE: begin
                pre_nxt = data_r ^ key_r;
              end
              REG_COUNT: begin
                main_nxt = data_r ^ key_r;
              end
              REG_KEY: begin
                key_nxt = data_r;
              end
              REG_NONE: begin
                key_nxt = key_r;
              end
            endcase
          end
          out_data_nxt  = {7'b0, pre_nxt, main_nxt, irq_nxt};
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control and timer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      tick_cnt_r  <= '0;
      en_r        <= 1'b0;
      ctrl_r      <= 8'h00;
      pre_r       <= 8'h00;
      main_r      <= 8'h00;
      key_r       <= 8'h00;
      irq_r       <= 1'b0;
      prev_addr_r <= 16'h0000;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      tick_cnt_r  <= tick_cnt_nxt;
      en_r        <= en_nxt;
      ctrl_r      <= ctrl_nxt;
      pre_r       <= pre_nxt;
      main_r      <= main_nxt;
      key_r       <= key_nxt;
      irq_r       <= irq_nxt;
      prev_addr_r <= prev_addr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    mode_r     <= mode_nxt;
    addr_r     <= addr_nxt;
    data_r     <= data_nxt;
    out_data_r <= out_data_nxt;
  end

  // the tick loop never runs with nothing left to do
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TICK) |-> (tick_cnt_r != '0))
    else $error("tick state with zero clocks left");

  // the interrupt line only rises from a prescaler clock
  assert property (@(posedge clk) disable iff (!rst_n)
    $rose(irq_r) |-> $past(state_r == ST_TICK))
    else $error("interrupt raised outside a tick");

  // an idle sequencer leaves the prescaler alone
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_IDLE) |=> $stable(pre_r))
    else $error("prescaler changed while idle");

  // a pending result is never overwritten before it is taken
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |=> (out_valid_r && $stable(out_data_r)))
    else $error("pending result lost");

endmodule
`default_nettype wire

@@ sim/prescaled_irq_counter_test.sv @@
// self-checking testbench for the prescaled interrupt timer
`default_nettype none
module prescaled_irq_counter_test;
  import psirq_pkg::*;

  // timer model plus the queue of results still owed by the block
  class timer_scoreboard;
    logic        enabled;
    logic [7:0]  control;
    logic [7:0]  prescale;
    logic [7:0]  count;
    logic [7:0]  key;
    logic        irq;
    logic [15:0] last_ppu;
    tick_res_t   due_results[$];
    int unsigned errors;

    function new();
      enabled  = 1'b0;
      control  = 8'h00;
      prescale = 8'h00;
      count    = 8'h00;
      key      = 8'h00;
      irq      = 1'b0;
      last_ppu = 16'h0000;
      errors   = 0;
    endfunction

    // one timer clock: prescaler step, carry into the counter, wrap check
    function void advance_timer();
      logic [7:0] mask;
      logic [7:0] p;
      logic [1:0] dir;
      logic       carry;
      if (!enabled) return;
      mask  = control[2] ? 8'h07 : 8'hFF;
      p     = prescale & mask;
      dir   = control[7:6];
      carry = 1'b0;
      if (dir == DIR_UP) begin
        p     = p + 8'd1;
        carry = ((p & mask) == 8'h00);
      end else if (dir == DIR_DOWN) begin
        p     = p - 8'd1;
        carry = ((p & mask) == mask);
      end
      prescale = (prescale & ~mask) | (p & mask);
      if (!carry) return;
      // bit 3 freezes the counter, the wrap check still runs
      if (dir == DIR_UP) begin
        if (!control[3]) count = count + 8'd1;
        if (count == 8'h00) irq = 1'b1;
      end else begin
        if (!control[3]) count = count - 8'd1;
        if (count == 8'hFF) irq = 1'b1;
      end
    endfunction

    function void note_request(mode_t m, logic [15:0] a, logic [7:0] d, logic [9:0] c);
      src_t src;
      src = src_t'(control[1:0]);
      case (m)
        MODE_CPU_WRITE: begin
          // the write clock comes ahead of the register update
          if (src == SRC_WRITE) advance_timer();
          if (a[15:12] == REG_PAGE) begin
            case (reg_sel_t'(a[2:0]))
              REG_ENABLE_SET: begin
                enabled = d[0];
                if (!d[0]) begin
                  prescale = 8'h00;
                  irq      = 1'b0;
                end
              end
              REG_CONTROL: control = d;
              REG_DISABLE: begin
                enabled  = 1'b0;
                prescale = 8'h00;
                irq      = 1'b0;
              end
              REG_ENABLE:   enabled  = 1'b1;
              REG_PRESCALE: prescale = d ^ key;
              REG_COUNT:    count    = d ^ key;
              REG_KEY:      key      = d;
              default: ;
            endcase
          end
        end
        MODE_CYCLES: if (src == SRC_CYCLES) repeat (c) advance_timer();
        MODE_PPU_ADDR: begin
          if (src == SRC_PPU && last_ppu != a) repeat (2) advance_timer();
          last_ppu = a;
        end
        default: if (src == SRC_SCANLINE) repeat (8) advance_timer();
      endcase
      due_results.push_back({prescale, count, irq});
    endfunction

    function void check_result(logic [23:0] td);
      tick_res_t got;
      tick_res_t want;
      got = td[16:0];
      if (due_results.size() == 0) begin
        $display("%0t unexpected result: expected none actual %h", $time, td);
        errors++;
        return;
      end
      want = due_results.pop_front();
      if (got.irq !== want.irq) begin
        $display("%0t irq_pending: expected %0d actual %0d", $time, want.irq, got.irq);
        errors++;
      end
      if (got.count !== want.count) begin
        $display("%0t counter_value: expected %h actual %h", $time, want.count, got.count);
        errors++;
      end
      if (got.prescale !== want.prescale) begin
        $display("%0t prescaler_value: expected %h actual %h", $time, want.prescale,
                 got.prescale);
        errors++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [39:0] in_tdata;   // mode[1:0], address[17:2], write_data[25:18], cycle_count[35:26]
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;  // irq_pending[0], counter_value[8:1], prescaler_value[16:9]

  timer_scoreboard sb = new();
  bit              calm;          // no idling on either side in the closing stretch
  bit              quiet_sender;  // no sender gaps for the current sequence
  int unsigned     requests_sent;

  prescaled_irq_counter i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // hard stop well past the slowest legal run
  initial begin
    #60_000_000;
    $display("prescaled_irq_counter regression: fail");
    $finish;
  end

  // receiver: ready stretches and stalls of random length
  initial begin
    forever begin
      out_tready <= 1'b1;
      repeat (($urandom_range(0, 7) == 0) ? 300 : $urandom_range(1, 40)) @(posedge clk);
      if (!calm) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 13)) @(posedge clk);
      end
    end
  end

  // every accepted result goes to the scoreboard
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready) sb.check_result(out_tdata);
  end

  // hold one request until the block takes it, then maybe leave a gap
  task automatic send_event(input mode_t m, input logic [15:0] a, input logic [7:0] d,
                            input logic [9:0] c);
    in_tvalid <= 1'b1;
    in_tdata  <= {4'b0000, c, d, a, m};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    sb.note_request(m, a, d, c);
    requests_sent++;
    if (!calm && !quiet_sender && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 13)) @(posedge clk);
    end
  endtask

  task automatic cpu_write(input logic [15:0] a, input logic [7:0] d);
    send_event(MODE_CPU_WRITE, a, d, 10'($urandom));
  endtask

  // sender holds off until every owed result is back
  task automatic drain();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (sb.due_results.size() != 0);
  endtask

  // register address in the c000-cfff page, random bits between page and select
  function automatic logic [15:0] reg_addr(reg_sel_t r);
    return {REG_PAGE, 9'($urandom), r};
  endfunction

  // mostly short batches, now and then a long one
  function automatic logic [9:0] batch_len();
    if ($urandom_range(0, 39) == 0) return 10'($urandom_range(512, 1023));
    return 10'($urandom_range(0, 24));
  endfunction

  // any event with random content
  task automatic noise_event();
    mode_t       m;
    logic [15:0] a;
    m = mode_t'($urandom_range(0, 3));
    a = 16'($urandom);
    if (m == MODE_CPU_WRITE && $urandom_range(0, 2) == 0)
      a = reg_addr(reg_sel_t'($urandom_range(0, 7)));
    send_event(m, a, 8'($urandom), (m == MODE_CYCLES) ? batch_len() : 10'($urandom));
  endtask

  // program the timer close to a wrap, enable it, then feed the chosen source
  task automatic run_sequence();
    logic [1:0]  src;
    logic [1:0]  dir;
    logic [7:0]  ctrl;
    logic [7:0]  key;
    logic [7:0]  mask;
    logic [7:0]  target;
    logic [15:0] a;
    src = 2'($urandom);
    case ($urandom_range(0, 9))
      0:         dir = 2'b00;
      1:         dir = 2'b11;
      2, 3, 4, 5: dir = DIR_UP;
      default:   dir = DIR_DOWN;
    endcase
    ctrl = {dir, 2'($urandom), ($urandom_range(0, 5) == 0), 1'($urandom), src};
    mask = ctrl[2] ? 8'h07 : 8'hFF;
    quiet_sender = ($urandom_range(0, 3) == 0);
    if ($urandom_range(0, 1) == 0) begin
      key = 8'($urandom);
      cpu_write(reg_addr(REG_KEY), key);
    end else begin
      key = sb.key;
    end
    cpu_write(reg_addr(REG_CONTROL), ctrl);
    // prescaler a few clocks away from its carry, upper bits random
    target = 8'($urandom);
    target = (target & ~mask) |
             (((dir == DIR_UP) ? mask - 8'($urandom_range(0, 3)) : 8'($urandom_range(0, 3)))
              & mask);
    cpu_write(reg_addr(REG_PRESCALE), target ^ key);
    // counter near its wrap most of the time
    if ($urandom_range(0, 3) == 0) target = 8'($urandom);
    else if (dir == DIR_UP) target = 8'hFF - 8'($urandom_range(0, 2));
    else target = 8'($urandom_range(0, 2));
    cpu_write(reg_addr(REG_COUNT), target ^ key);
    if ($urandom_range(0, 1) == 0) cpu_write(reg_addr(REG_ENABLE), 8'($urandom));
    else cpu_write(reg_addr(REG_ENABLE_SET), 8'($urandom) | 8'h01);
    repeat ($urandom_range(4, 20)) begin
      if ($urandom_range(0, 9) < 2) begin
        noise_event();
      end else begin
        case (src_t'(src))
          SRC_CYCLES:
            send_event(MODE_CYCLES, 16'($urandom), 8'($urandom), batch_len());
          SRC_SCANLINE:
            send_event(MODE_SCANLINE, 16'($urandom), 8'($urandom), 10'($urandom));
          SRC_PPU: begin
            a = ($urandom_range(0, 3) == 0) ? sb.last_ppu : 16'($urandom);
            send_event(MODE_PPU_ADDR, a, 8'($urandom), 10'($urandom));
          end
          default: begin
            // write clocks: off-page writes, or the unused register slot
            a = 16'($urandom);
            if (a[15:12] == REG_PAGE) a[15] = 1'b0;
            if ($urandom_range(0, 3) == 0) a = reg_addr(REG_NONE);
            cpu_write(a, 8'($urandom));
          end
        endcase
      end
    end
  endtask

  initial begin
    bit drained_mid;
    rst_n      <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    calm          = 1'b0;
    quiet_sender  = 1'b0;
    drained_mid   = 1'b0;
    requests_sent = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed part
    send_event(MODE_CYCLES, 16'h0000, 8'h00, 10'd5);          // disabled timer ignores clocks
    cpu_write(reg_addr(REG_KEY), 8'h5A);
    cpu_write(reg_addr(REG_PRESCALE), 8'hFD ^ 8'h5A);          // xor-masked loads
    cpu_write(reg_addr(REG_COUNT), 8'hFF ^ 8'h5A);
    cpu_write(reg_addr(REG_CONTROL), 8'h40);                   // up, 8-bit, cycle source
    cpu_write(reg_addr(REG_ENABLE), 8'h00);
    send_event(MODE_CYCLES, 16'hFFFF, 8'hFF, 10'd3);           // carry wraps counter to zero
    send_event(MODE_CYCLES, 16'h0000, 8'h00, 10'd1023);        // longest batch
    cpu_write(reg_addr(REG_DISABLE), 8'hFF);
    cpu_write(reg_addr(REG_ENABLE_SET), 8'h01);
    cpu_write(reg_addr(REG_CONTROL), 8'h85);                   // down, 3-bit, scanline source
    send_event(MODE_SCANLINE, 16'h0000, 8'h00, 10'd0);         // down carry
    cpu_write(reg_addr(REG_CONTROL), 8'h8E);                   // down, frozen, 3-bit, ppu source
    send_event(MODE_PPU_ADDR, 16'h2000, 8'h00, 10'd0);
    send_event(MODE_PPU_ADDR, 16'h2000, 8'hFF, 10'h3FF);       // same address, no clocks
    send_event(MODE_PPU_ADDR, 16'hFFFF, 8'h00, 10'd0);
    cpu_write(reg_addr(REG_CONTROL), 8'hC3);                   // hold direction, write source
    cpu_write(16'h8000, 8'h00);                                // off-page write only clocks
    cpu_write(reg_addr(REG_CONTROL), 8'h4B);                   // up, frozen, write source
    cpu_write(reg_addr(REG_NONE), 8'hFF);
    cpu_write(16'hFFFF, 8'h00);
    cpu_write(reg_addr(REG_ENABLE_SET), 8'hFE);                // write clocks, then disables
    send_event(MODE_CYCLES, 16'h0000, 8'h00, 10'd0);
    drain();

    // random part
    while (requests_sent < 1150) begin
      if (requests_sent >= 1000) calm = 1'b1;
      if (!drained_mid && requests_sent >= 600) begin
        drain();
        drained_mid = 1'b1;
      end
      run_sequence();
    end

    drain();
    repeat (40) @(posedge clk);
    if (sb.errors == 0 && sb.due_results.size() == 0) begin
      $display("prescaled_irq_counter regression: pass");
    end else begin
      $display("prescaled_irq_counter regression: fail");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ files.f @@
src/psirq_pkg.sv
src/psirq_tick.sv
src/prescaled_irq_counter.sv
sim/prescaled_irq_counter_test.sv
